FILE: design/table_waveform_generator_core_macros.svh
// assertion macros shared by the table waveform generator rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef TABLE_WAVEFORM_GENERATOR_CORE_MACROS_SVH
`define TABLE_WAVEFORM_GENERATOR_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define TWG_ASSERT_IMPLIES(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("twg implication check failed");

// next-cycle implication, checked out of reset
`define TWG_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("twg next-cycle check failed");

`endif

FILE: design/twg_pkg.sv
// shared types, constants and the sine table of the table waveform generator
// no dependencies
`default_nettype none

package twg_pkg;

    localparam int SinePoints  = 400;
    localparam int RampPoints  = 100;
    localparam int StairPoints = 20;
    localparam int RomLen      = 400;
    localparam int RomAw       = $clog2(RomLen);

    localparam int MaxPoints = (SinePoints > RampPoints)
                             ? ((SinePoints > StairPoints) ? SinePoints : StairPoints)
                             : ((RampPoints > StairPoints) ? RampPoints : StairPoints);
    localparam int IdxW = $clog2(MaxPoints);
    localparam int CntW = IdxW + 1;

    localparam int ByteW   = 8;
    localparam int FreqW   = 8;
    localparam int DurW    = 14;
    localparam int RepsW   = 22;
    localparam int PeriodW = 10;
    localparam int HoldW   = 10;
    localparam int LevelW  = 16;
    localparam int OutW    = 24;

    localparam logic [PeriodW-1:0] PeriodNum  = PeriodW'(1000);
    localparam logic [LevelW-1:0]  SquareHigh = LevelW'(65500);
    localparam logic [LevelW-1:0]  SineMid    = LevelW'(3250);
    localparam int                 RampStep   = 650;
    localparam int                 StairStep  = 6553;

    // wave codes from the low bits of the first command byte
    localparam logic [2:0] WAVE_SINE     = 3'd1;
    localparam logic [2:0] WAVE_SQUARE   = 3'd2;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
    localparam logic [2:0] WAVE_SAW      = 3'd4;
    localparam logic [2:0] WAVE_STAIR    = 3'd5;
    localparam logic [2:0] WAVE_RECT     = 3'd6;

    typedef enum logic [1:0] {
        ITEM_TICK = 2'd0,
        ITEM_ZERO = 2'd1,
        ITEM_DATA = 2'd2
    } item_kind_t;

    typedef struct packed {
        item_kind_t        kind;
        logic [ByteW-1:0]  data;
    } item_t;

    typedef struct packed {
        logic               done;
        logic [PeriodW-1:0] quotient;
    } div_rsp_t;

    localparam logic [15:0] SineRom [RomLen] = '{
        16'd3250,16'd3301,16'd3352,16'd3403,16'd3454,16'd3504,16'd3555,16'd3606,16'd3657,16'd3707,
        16'd3758,16'd3808,16'd3858,16'd3909,16'd3958,16'd4008,16'd4058,16'd4107,16'd4156,16'd4205,
        16'd4254,16'd4302,16'd4350,16'd4398,16'd4446,16'd4493,16'd4540,16'd4587,16'd4633,16'd4679,
        16'd4725,16'd4770,16'd4815,16'd4860,16'd4904,16'd4948,16'd4991,16'd5034,16'd5076,16'd5118,
        16'd5160,16'd5201,16'd5241,16'd5282,16'd5321,16'd5360,16'd5399,16'd5437,16'd5474,16'd5511,
        16'd5548,16'd5583,16'd5619,16'd5653,16'd5687,16'd5721,16'd5754,16'd5786,16'd5818,16'd5848,
        16'd5879,16'd5908,16'd5938,16'd5966,16'd5994,16'd6021,16'd6047,16'd6073,16'd6097,16'd6122,
        16'd6145,16'd6168,16'd6190,16'd6212,16'd6232,16'd6252,16'd6271,16'd6290,16'd6307,16'd6324,
        16'd6340,16'd6356,16'd6370,16'd6384,16'd6397,16'd6410,16'd6421,16'd6432,16'd6442,16'd6451,
        16'd6459,16'd6467,16'd6474,16'd6480,16'd6485,16'd6489,16'd6493,16'd6496,16'd6498,16'd6499,
        16'd6500,16'd6499,16'd6498,16'd6496,16'd6493,16'd6489,16'd6485,16'd6480,16'd6474,16'd6467,
        16'd6459,16'd6451,16'd6442,16'd6432,16'd6421,16'd6410,16'd6397,16'd6384,16'd6370,16'd6356,
        16'd6340,16'd6324,16'd6307,16'd6290,16'd6271,16'd6252,16'd6232,16'd6212,16'd6190,16'd6168,
        16'd6145,16'd6122,16'd6097,16'd6073,16'd6047,16'd6021,16'd5994,16'd5966,16'd5938,16'd5908,
        16'd5879,16'd5848,16'd5818,16'd5786,16'd5754,16'd5721,16'd5687,16'd5653,16'd5619,16'd5583,
        16'd5548,16'd5511,16'd5474,16'd5437,16'd5399,16'd5360,16'd5321,16'd5282,16'd5241,16'd5201,
        16'd5160,16'd5118,16'd5076,16'd5034,16'd4991,16'd4948,16'd4904,16'd4860,16'd4815,16'd4770,
        16'd4725,16'd4679,16'd4633,16'd4587,16'd4540,16'd4493,16'd4446,16'd4398,16'd4350,16'd4302,
        16'd4254,16'd4205,16'd4156,16'd4107,16'd4058,16'd4008,16'd3958,16'd3909,16'd3858,16'd3808,
        16'd3758,16'd3707,16'd3657,16'd3606,16'd3555,16'd3504,16'd3454,16'd3403,16'd3352,16'd3301,
        16'd3250,16'd3199,16'd3148,16'd3097,16'd3046,16'd2996,16'd2945,16'd2894,16'd2843,16'd2793,
        16'd2742,16'd2692,16'd2642,16'd2591,16'd2542,16'd2492,16'd2442,16'd2393,16'd2344,16'd2295,
        16'd2246,16'd2198,16'd2150,16'd2102,16'd2054,16'd2007,16'd1960,16'd1913,16'd1867,16'd1821,
        16'd1775,16'd1730,16'd1685,16'd1640,16'd1596,16'd1552,16'd1509,16'd1466,16'd1424,16'd1382,
        16'd1340,16'd1299,16'd1259,16'd1218,16'd1179,16'd1140,16'd1101,16'd1063,16'd1026,16'd989,
        16'd952,16'd917,16'd881,16'd847,16'd813,16'd779,16'd746,16'd714,16'd682,16'd652,
        16'd621,16'd592,16'd562,16'd534,16'd506,16'd479,16'd453,16'd427,16'd403,16'd378,
        16'd355,16'd332,16'd310,16'd288,16'd268,16'd248,16'd229,16'd210,16'd193,16'd176,
        16'd160,16'd144,16'd130,16'd116,16'd103,16'd90,16'd79,16'd68,16'd58,16'd49,
        16'd41,16'd33,16'd26,16'd20,16'd15,16'd11,16'd7,16'd4,16'd2,16'd1,
        16'd0,16'd1,16'd2,16'd4,16'd7,16'd11,16'd15,16'd20,16'd26,16'd33,
        16'd41,16'd49,16'd58,16'd68,16'd79,16'd90,16'd103,16'd116,16'd130,16'd144,
        16'd160,16'd176,16'd193,16'd210,16'd229,16'd248,16'd268,16'd288,16'd310,16'd332,
        16'd355,16'd378,16'd403,16'd427,16'd453,16'd479,16'd506,16'd534,16'd562,16'd592,
        16'd621,16'd652,16'd682,16'd714,16'd746,16'd779,16'd813,16'd847,16'd881,16'd917,
        16'd952,16'd989,16'd1026,16'd1063,16'd1101,16'd1140,16'd1179,16'd1218,16'd1259,16'd1299,
        16'd1340,16'd1382,16'd1424,16'd1466,16'd1509,16'd1552,16'd1596,16'd1640,16'd1685,16'd1730,
        16'd1775,16'd1821,16'd1867,16'd1913,16'd1960,16'd2007,16'd2054,16'd2102,16'd2150,16'd2198,
        16'd2246,16'd2295,16'd2344,16'd2393,16'd2442,16'd2492,16'd2542,16'd2591,16'd2642,16'd2692,
        16'd2742,16'd2793,16'd2843,16'd2894,16'd2945,16'd2996,16'd3046,16'd3097,16'd3148,16'd3199
    };

endpackage

`default_nettype wire

FILE: design/twg_front.sv
// input side of the table waveform generator: takes requests and classifies them
// depends on twg_pkg
`default_nettype none

module twg_front (
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // rx_byte
    input  wire logic                 s_tuser,   // func
    input  wire logic                 q_full,
    output logic                      q_push,
    output twg_pkg::item_t            q_item
);
    import twg_pkg::*;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb
    begin
        q_item.data = s_tdata;
        if (s_tuser)
        begin
            q_item.kind = ITEM_TICK;
        end
        else if (s_tdata == '0)
        begin
            q_item.kind = ITEM_ZERO;
        end
        else
        begin
            q_item.kind = ITEM_DATA;
        end
    end

endmodule

`default_nettype wire

FILE: design/twg_queue.sv
// two-entry request queue between the front and back of the generator
// depends on twg_pkg
`default_nettype none

module twg_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire twg_pkg::item_t push_item,
    output logic                full,
    input  wire logic           pop,
    output logic                empty,
    output twg_pkg::item_t      pop_item
);
    import twg_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_item = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/twg_div.sv
// restoring divider for the period, one quotient bit per cycle
// depends on twg_pkg
`default_nettype none

module twg_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [twg_pkg::FreqW-1:0] divisor,
    output twg_pkg::div_rsp_t              rsp
);
    import twg_pkg::*;

    localparam int StepW = $clog2(PeriodW);

    logic [FreqW-1:0]   d_reg;
    logic [FreqW-1:0]   rem_reg;
    logic [PeriodW-1:0] num_reg;
    logic [StepW-1:0]   step_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [FreqW:0]     trial;
    logic               ge;

    assign trial = {rem_reg, num_reg[PeriodW-1]};
    assign ge    = (trial >= {1'b0, d_reg});

    assign rsp.done     = done_reg;
    assign rsp.quotient = num_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d_reg   <= divisor;
            rem_reg <= '0;
            num_reg <= PeriodNum;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? FreqW'(trial - {1'b0, d_reg}) : FreqW'(trial);
            num_reg <= {num_reg[PeriodW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                step_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == StepW'(PeriodW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/twg_back.sv
// back end of the generator: command decode, wave playback and result register
// depends on twg_pkg, twg_div and the assertion macro header
`default_nettype none
`include "table_waveform_generator_core_macros.svh"

module twg_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      q_empty,
    input  wire twg_pkg::item_t            q_item,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [twg_pkg::OutW-1:0]       m_tdata   // level[15:0], playing, bad_freq
);
    import twg_pkg::*;

    typedef enum logic [2:0] {
        PH_WAIT   = 3'b001,
        PH_GATHER = 3'b010,
        PH_PLAY   = 3'b100
    } phase_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIV   = 5'b00010,
        ST_CALC  = 5'b00100,
        ST_ROM   = 5'b01000,
        ST_LEVEL = 5'b10000
    } state_t;

    // sine table address i * RomLen / SinePoints by reciprocal multiply,
    // exact for every index below SinePoints
    localparam int          SineAddrSh  = 32;
    localparam logic [63:0] SineAddrMul =
        ((64'(RomLen) << SineAddrSh) + 64'(SinePoints) - 64'd1) / 64'(SinePoints);

    function automatic logic [CntW-1:0] cycle_len(input logic [2:0] k);
        case (k) inside
            WAVE_SINE:               return CntW'(SinePoints);
            WAVE_SQUARE:             return CntW'(2);
            WAVE_TRIANGLE, WAVE_SAW: return CntW'(RampPoints);
            WAVE_STAIR:              return CntW'(StairPoints);
            default:                 return CntW'(SinePoints / 2);
        endcase
    endfunction

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [1:0]         slot_reg, slot_next;
    logic [ByteW-1:0]   cmd_reg [3];
    logic [ByteW-1:0]   cmd_next [3];
    logic [2:0]         kind_reg, kind_next;
    logic [2:0]         newkind_reg, newkind_next;
    logic [RepsW-1:0]   reps_reg, reps_next;
    logic [HoldW-1:0]   hold_reg, hold_next;
    logic [RepsW-1:0]   left_reg, left_next;
    logic [IdxW-1:0]    idx_reg, idx_next;
    logic               down_reg, down_next;
    logic [HoldW-1:0]   tick_reg, tick_next;
    logic [LevelW-1:0]  level_reg, level_next;
    logic               ferr_reg, ferr_next;
    logic [LevelW-1:0]  rom_reg;
    logic               out_valid_reg, out_valid_next;
    logic [OutW-1:0]    out_data_reg;
    logic               emit;

    logic               div_start;
    logic [FreqW-1:0]   freq;
    logic [DurW-1:0]    dur;
    div_rsp_t           div_rsp;

    logic [HoldW-1:0]   hold_eff;
    logic [HoldW:0]     tick_inc;
    logic [CntW-1:0]    idx_inc;
    logic [CntW-1:0]    len_cur;
    logic [RomAw-1:0]   rom_addr;
    logic [RepsW-1:0]   cycles;
    logic [15:0]        hold100_prod;
    logic [17:0]        hold10_prod;
    logic [CntW-1:0]    stair_k;
    logic [CntW-1:0]    ramp_i;
    logic [LevelW-1:0]  sample;

    twg_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .divisor (freq),
        .rsp     (div_rsp)
    );

    assign freq     = q_item.data | {1'b0, cmd_reg[2][ByteW-1:1]};
    assign dur      = {cmd_reg[2][0], cmd_reg[1], cmd_reg[0][ByteW-1:3]};
    assign hold_eff = (hold_reg == '0) ? HoldW'(1) : hold_reg;
    assign tick_inc = {1'b0, tick_reg} + 1'b1;
    assign idx_inc  = {1'b0, idx_reg} + 1'b1;
    assign len_cur  = cycle_len(kind_reg);
    assign rom_addr = RomAw'((64'(idx_reg) * SineAddrMul) >> SineAddrSh);

    // period / 100 and period / 10 by reciprocal multiply, exact for periods up to 1000
    assign hold100_prod = 16'(div_rsp.quotient) * 16'd41;
    assign hold10_prod  = 18'(div_rsp.quotient) * 18'd205;

    always_comb
    begin
        case (newkind_reg) inside
            WAVE_SINE:                           cycles = reps_reg >> 2;
            WAVE_SQUARE, WAVE_TRIANGLE, WAVE_RECT: cycles = reps_reg >> 1;
            default:                             cycles = reps_reg;
        endcase
    end

    // sample of the current index
    always_comb
    begin
        ramp_i  = down_reg ? CntW'(RampPoints - 1) - {1'b0, idx_reg} : {1'b0, idx_reg};
        stair_k = ({1'b0, idx_reg} <= CntW'(StairPoints) - {1'b0, idx_reg})
                ? {1'b0, idx_reg} : CntW'(StairPoints) - {1'b0, idx_reg};
        case (kind_reg) inside
            WAVE_SINE:               sample = rom_reg;
            WAVE_SQUARE:             sample = (idx_reg == '0) ? SquareHigh : '0;
            WAVE_TRIANGLE, WAVE_SAW: sample = LevelW'(32'(ramp_i) * RampStep);
            WAVE_STAIR:              sample = LevelW'(32'(stair_k) * StairStep);
            default:                 sample = (rom_reg >= SineMid)
                                            ? LevelW'({rom_reg - SineMid, 1'b0}) : '0;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        slot_next    = slot_reg;
        cmd_next     = cmd_reg;
        kind_next    = kind_reg;
        newkind_next = newkind_reg;
        reps_next    = reps_reg;
        hold_next    = hold_reg;
        left_next    = left_reg;
        idx_next     = idx_reg;
        down_next    = down_reg;
        tick_next    = tick_reg;
        level_next   = level_reg;
        ferr_next    = ferr_reg;
        q_pop        = 1'b0;
        div_start    = 1'b0;
        emit         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty && !out_valid_reg)
                begin
                    q_pop = 1'b1;
                    unique case (phase_reg)
                        PH_PLAY:
                        begin
                            if (q_item.kind != ITEM_TICK)
                            begin
                                emit = 1'b1;
                            end
                            else if (tick_inc < {1'b0, hold_eff})
                            begin
                                tick_next = HoldW'(tick_inc);
                                emit      = 1'b1;
                            end
                            else
                            begin
                                tick_next  = '0;
                                state_next = ST_ROM;
                                if (idx_inc >= len_cur)
                                begin
                                    idx_next = '0;
                                    if (kind_reg == WAVE_TRIANGLE && !down_reg)
                                    begin
                                        down_next = 1'b1;
                                    end
                                    else
                                    begin
                                        down_next = 1'b0;
                                        left_next = left_reg - 1'b1;
                                        if (left_reg == RepsW'(1))
                                        begin
                                            phase_next = PH_WAIT;
                                            state_next = ST_IDLE;
                                            emit       = 1'b1;
                                        end
                                    end
                                end
                                else
                                begin
                                    idx_next = IdxW'(idx_inc);
                                end
                            end
                        end
                        PH_GATHER:
                        begin
                            if (q_item.kind == ITEM_TICK)
                            begin
                                emit = 1'b1;
                            end
                            else if (slot_reg != 2'd3)
                            begin
                                cmd_next[slot_reg] = q_item.data;
                                slot_next          = slot_reg + 2'd1;
                                emit               = 1'b1;
                            end
                            else
                            begin
                                slot_next  = 2'd0;
                                phase_next = PH_WAIT;
                                if (freq == '0)
                                begin
                                    ferr_next = 1'b1;
                                    emit      = 1'b1;
                                end
                                else
                                begin
                                    ferr_next    = 1'b0;
                                    div_start    = 1'b1;
                                    newkind_next = cmd_reg[0][2:0];
                                    reps_next    = RepsW'(dur * RepsW'(freq));
                                    state_next   = ST_DIV;
                                end
                            end
                        end
                        default:
                        begin
                            if (q_item.kind == ITEM_ZERO)
                            begin
                                phase_next = PH_GATHER;
                                slot_next  = 2'd0;
                            end
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (newkind_reg == 3'd0 || newkind_reg == 3'd7 || cycles == '0)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    kind_next = newkind_reg;
                    case (newkind_reg) inside
                        WAVE_SQUARE: hold_next = div_rsp.quotient;
                        WAVE_STAIR:  hold_next = HoldW'(hold10_prod >> 11);
                        default:     hold_next = HoldW'(hold100_prod >> 12);
                    endcase
                    left_next  = cycles;
                    idx_next   = '0;
                    down_next  = 1'b0;
                    tick_next  = '0;
                    phase_next = PH_PLAY;
                    state_next = ST_ROM;
                end
            end
            ST_ROM:
            begin
                state_next = ST_LEVEL;
            end
            ST_LEVEL:
            begin
                level_next = sample;
                emit       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = emit || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk)
    begin
        rom_reg      <= SineRom[rom_addr];
        newkind_reg  <= newkind_next;
        reps_reg     <= reps_next;
        if (emit)
        begin
            out_data_reg <= {(OutW - LevelW - 2)'(0), ferr_next,
                             phase_next == PH_PLAY, level_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_WAIT;
            slot_reg      <= 2'd0;
            cmd_reg       <= '{default: '0};
            kind_reg      <= '0;
            hold_reg      <= '0;
            left_reg      <= '0;
            idx_reg       <= '0;
            down_reg      <= 1'b0;
            tick_reg      <= '0;
            level_reg     <= '0;
            ferr_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            slot_reg      <= slot_next;
            cmd_reg       <= cmd_next;
            kind_reg      <= kind_next;
            hold_reg      <= hold_next;
            left_reg      <= left_next;
            idx_reg       <= idx_next;
            down_reg      <= down_next;
            tick_reg      <= tick_next;
            level_reg     <= level_next;
            ferr_reg      <= ferr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `TWG_ASSERT_IMPLIES(a_pop_needs_free_out, clk, rst_n, q_pop, !out_valid_reg)
    `TWG_ASSERT_IMPLIES(a_tick_below_hold, clk, rst_n, phase_reg == PH_PLAY, tick_reg < hold_eff)
    `TWG_ASSERT_IMPLIES(a_index_in_cycle, clk, rst_n, phase_reg == PH_PLAY, idx_inc <= len_cur)
    `TWG_ASSERT_NEXT(a_div_to_calc, clk, rst_n, state_reg == ST_DIV && div_rsp.done, state_reg == ST_CALC)

endmodule

`default_nettype wire

FILE: design/table_waveform_generator_core.sv
// top level of the table waveform generator: byte/tick stream in, port level stream out
// depends on twg_pkg, twg_front, twg_queue, twg_back
//
// usage
//   slave channel: one request per received serial byte (tuser = 0, tdata = byte) or per
//   millisecond tick (tuser = 1). a zero byte arms the block, four command bytes follow:
//   wave code and duration in the first three, frequency in the third and fourth
//   master channel: one result per request, the port level with the playing and
//   bad-frequency flags
//   a byte or a tick that holds the sample is answered from the idle state; a tick that
//   moves to the next sample passes the rom and level states; the fourth command byte
//   runs the period divider and the calc state before the first sample is read from the
//   sine table; the back-end sequencer finishes each request, and its result leaves the
//   output register, before it takes the next
//   a two-entry queue keeps the slave side accepting while the back end is busy
//   or while a result waits in the output register
//   receiver stall: the result holds in the output register; the back end stops and
//   the queue fills, then tready drops
//   reset: asynchronous, clears the queue, the output valid flag and all playback state;
//   the level reads zero and the block waits for a zero byte
`default_nettype none

module table_waveform_generator_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [7:0]                s_tdata,   // rx_byte
    input  wire logic                      s_tuser,   // func
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [twg_pkg::OutW-1:0]       m_tdata    // level[15:0], playing, bad_freq
);
    import twg_pkg::*;

    // request queue between front and back
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    item_t push_item;
    item_t pop_item;

    twg_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    twg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_item  (pop_item)
    );

    // decode, divide, play and hold the result
    twg_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (pop_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

FILE: tb/table_waveform_generator_core_tb.sv
// self-checking testbench for the table waveform generator core
// depends on twg_pkg (sine table and wave codes) and table_waveform_generator_core
`default_nettype none

module table_waveform_generator_core_tb;
    import twg_pkg::*;

    localparam int WatchdogLimit = 20000;
    localparam int DrainCycles   = 40;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } request_t;

    typedef struct packed {
        logic [15:0] level;
        logic        playing;
        logic        bad_freq;
    } level_report_t;

    // playback phases of the predictor
    typedef enum logic [1:0] {
        PH_WAIT   = 2'd0,
        PH_GATHER = 2'd1,
        PH_PLAY   = 2'd2
    } play_phase_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [7:0] s_tdata;   // rx_byte
    logic s_tuser;         // func
    logic m_tvalid;
    logic m_tready;
    logic [OutW-1:0] m_tdata;   // level[15:0], playing, bad_freq, zero fill

    table_waveform_generator_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // predictor state
    play_phase_t gen_phase;
    int unsigned gen_slot;
    logic [7:0]  gen_cmd [3];
    logic [2:0]  gen_wave;
    int unsigned gen_hold;
    int unsigned gen_cycles_left;
    int unsigned gen_index;
    logic        gen_down;
    int unsigned gen_ticks;
    logic [15:0] gen_level;
    logic        gen_bad_freq;

    request_t      pending_requests[$];
    level_report_t expected_levels[$];
    int            error_count;
    bit            hold_receiver;
    int            idle_cycles;

    function automatic logic [15:0] sine_sample(int unsigned i);
        int unsigned r;
        r = (i * RomLen) / SinePoints;
        if (r >= RomLen)
            r = RomLen - 1;
        return SineRom[r];
    endfunction

    function automatic int unsigned points_per_cycle(logic [2:0] w);
        case (w)
            WAVE_SINE:               return SinePoints;
            WAVE_SQUARE:             return 2;
            WAVE_TRIANGLE, WAVE_SAW: return RampPoints;
            WAVE_STAIR:              return StairPoints;
            default:                 return SinePoints / 2;
        endcase
    endfunction

    function automatic logic [15:0] wave_sample(logic [2:0] w, int unsigned i, logic down);
        int unsigned k;
        logic [15:0] s;
        case (w)
            WAVE_SINE:     return sine_sample(i);
            WAVE_SQUARE:   return (i == 0) ? SquareHigh : 16'd0;
            WAVE_TRIANGLE: return 16'((down ? RampPoints - 1 - i : i) * RampStep);
            WAVE_SAW:      return 16'(i * RampStep);
            WAVE_STAIR:
            begin
                k = (i <= StairPoints - i) ? i : StairPoints - i;
                return 16'(k * StairStep);
            end
            default:
            begin
                s = sine_sample(i);
                return (s >= SineMid) ? 16'((s - SineMid) * 2) : 16'd0;
            end
        endcase
    endfunction

    task automatic gen_reset();
        gen_phase = PH_WAIT;
        gen_slot = 0;
        gen_cmd = '{8'd0, 8'd0, 8'd0};
        gen_wave = 3'd0;
        gen_hold = 0;
        gen_cycles_left = 0;
        gen_index = 0;
        gen_down = 1'b0;
        gen_ticks = 0;
        gen_level = 16'd0;
        gen_bad_freq = 1'b0;
    endtask

    // decode the four command bytes and start playback when the command is usable
    task automatic gen_start(logic [7:0] b3);
        logic [2:0]  kind;
        int unsigned dur, freq, period, reps, cycles, hold;
        kind = gen_cmd[0][2:0];
        dur  = {gen_cmd[2][0], gen_cmd[1], gen_cmd[0][7:3]};
        freq = b3 | (gen_cmd[2] >> 1);
        gen_phase = PH_WAIT;
        if (freq == 0)
        begin
            gen_bad_freq = 1'b1;
            return;
        end
        gen_bad_freq = 1'b0;
        period = 1000 / freq;
        reps = dur * freq;
        case (kind)
            WAVE_SINE:     begin cycles = reps / 4; hold = period / 100; end
            WAVE_SQUARE:   begin cycles = reps / 2; hold = period;       end
            WAVE_TRIANGLE: begin cycles = reps / 2; hold = period / 100; end
            WAVE_SAW:      begin cycles = reps;     hold = period / 100; end
            WAVE_STAIR:    begin cycles = reps;     hold = period / 10;  end
            WAVE_RECT:     begin cycles = reps / 2; hold = period / 100; end
            default:       return;
        endcase
        if (cycles == 0)
            return;
        gen_wave = kind;
        gen_hold = hold;
        gen_cycles_left = cycles;
        gen_index = 0;
        gen_down = 1'b0;
        gen_ticks = 0;
        gen_phase = PH_PLAY;
        gen_level = wave_sample(gen_wave, 0, 1'b0);
    endtask

    task automatic gen_tick();
        int unsigned hold;
        hold = (gen_hold == 0) ? 1 : gen_hold;
        gen_ticks++;
        if (gen_ticks < hold)
            return;
        gen_ticks = 0;
        gen_index++;
        if (gen_index >= points_per_cycle(gen_wave))
        begin
            gen_index = 0;
            if (gen_wave == WAVE_TRIANGLE && !gen_down)
                gen_down = 1'b1;
            else
            begin
                gen_down = 1'b0;
                gen_cycles_left--;
                if (gen_cycles_left == 0)
                begin
                    gen_phase = PH_WAIT;
                    return;
                end
            end
        end
        gen_level = wave_sample(gen_wave, gen_index, gen_down);
    endtask

    // one request in, one expected port report out
    task automatic predict_level(request_t req);
        level_report_t exp;
        if (gen_phase == PH_PLAY)
        begin
            if (req.func)
                gen_tick();
        end
        else if (gen_phase == PH_GATHER)
        begin
            if (!req.func)
            begin
                if (gen_slot < 3)
                begin
                    gen_cmd[gen_slot] = req.rx_byte;
                    gen_slot++;
                end
                else
                begin
                    gen_slot = 0;
                    gen_start(req.rx_byte);
                end
            end
        end
        else if (!req.func && req.rx_byte == 8'd0)
        begin
            gen_phase = PH_GATHER;
            gen_slot = 0;
        end
        exp.level = gen_level;
        exp.playing = (gen_phase == PH_PLAY);
        exp.bad_freq = gen_bad_freq;
        expected_levels.push_back(exp);
    endtask

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // stimulus helpers
    task automatic add_byte(logic [7:0] b);
        request_t r;
        r.func = 1'b0;
        r.rx_byte = b;
        pending_requests.push_back(r);
    endtask

    task automatic add_ticks(int n);
        request_t r;
        for (int i = 0; i < n; i++)
        begin
            r.func = 1'b1;
            r.rx_byte = 8'($urandom);
            pending_requests.push_back(r);
        end
    endtask

    // zero byte, then the four command bytes built from wave, duration and frequency
    task automatic add_command(logic [2:0] wave, logic [13:0] dur, logic [7:0] freq);
        logic [7:0] b2, b3;
        b2 = {freq[6:0], dur[13]};
        b3 = freq & 8'($urandom) | {freq[7], 7'd0};
        b3 = b3 | (freq & ~8'(b2 >> 1));
        add_byte(8'd0);
        add_byte({dur[4:0], wave});
        add_byte(dur[12:5]);
        add_byte(b2);
        add_byte(b3);
    endtask

    // driver: one request at a time with a random gap before each
    int unsigned send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'd0;
            s_tuser <= 1'b0;
            send_gap <= 0;
        end
        else if (s_tvalid && !s_tready)
        begin
            // hold the offered request
        end
        else if (send_gap != 0)
        begin
            s_tvalid <= 1'b0;
            send_gap <= send_gap - 1;
        end
        else if (pending_requests.size() != 0)
        begin
            request_t r;
            r = pending_requests.pop_front();
            predict_level(r);
            s_tvalid <= 1'b1;
            s_tdata <= r.rx_byte;
            s_tuser <= r.func;
            send_gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 8);
        end
        else
            s_tvalid <= 1'b0;
    end

    // monitor: random receiver stalls, field checks on every accepted result
    int unsigned recv_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                level_report_t got, exp;
                got.level = m_tdata[15:0];
                got.playing = m_tdata[16];
                got.bad_freq = m_tdata[17];
                if (expected_levels.size() == 0)
                begin
                    $display("unexpected result at %0t", $realtime);
                    error_count++;
                end
                else
                begin
                    exp = expected_levels.pop_front();
                    if (got.level !== exp.level)
                        report_mismatch("level", got.level, exp.level);
                    if (got.playing !== exp.playing)
                        report_mismatch("playing", got.playing, exp.playing);
                    if (got.bad_freq !== exp.bad_freq)
                        report_mismatch("bad_freq", got.bad_freq, exp.bad_freq);
                end
                recv_gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 8);
                m_tready <= 1'b0;
            end
            else if (hold_receiver)
                m_tready <= 1'b0;
            else if (recv_gap != 0)
            begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog: cycles without any accepted request or result
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit)
            begin
                $display("watchdog expired at %0t", $realtime);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_requests.size() != 0 || s_tvalid || expected_levels.size() != 0)
            @(posedge clk);
    endtask

    // random command: mostly short playable ones, some malformed
    task automatic add_random_command();
        logic [2:0]  wave;
        logic [13:0] dur;
        logic [7:0]  freq;
        int          pick;
        wave = 3'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 7)
        begin
            // high frequency keeps hold short; small repeat count keeps play short
            freq = 8'($urandom_range(100, 255));
            dur = 14'($urandom_range(0, 1));
            if (wave == WAVE_SINE || wave == WAVE_RECT || wave == WAVE_TRIANGLE)
                freq = 8'($urandom_range(2, 8));
        end
        else if (pick < 8)
        begin
            freq = 8'd0;
            dur = 14'($urandom);
        end
        else
        begin
            freq = 8'($urandom);
            dur = 14'($urandom);
            wave = $urandom_range(0, 1) ? 3'd0 : 3'd7;
        end
        add_command(wave, dur, freq);
    endtask

    initial
    begin
        int n;
        error_count = 0;
        hold_receiver = 0;
        gen_reset();
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: ignored items, zero frequency, unused wave codes, a zero repeat count, square
        add_ticks(2);
        add_byte(8'hFF);
        add_command(WAVE_SINE, 14'h3FFF, 8'd0);
        add_command(3'd0, 14'd5, 8'd10);
        add_command(3'd7, 14'd5, 8'd10);
        add_command(WAVE_SQUARE, 14'd0, 8'd255);
        add_byte(8'h80);
        add_command(WAVE_SQUARE, 14'd1, 8'd255);
        add_byte(8'h55);
        add_ticks(4);
        wait_drained();

        // long receiver hold while a command and its ticks are offered, then wait until all results are in
        hold_receiver = 1;
        add_command(WAVE_SAW, 14'd1, 8'd255);
        add_ticks(30);
        repeat (120) @(posedge clk);
        hold_receiver = 0;
        wait_drained();

        add_command(WAVE_STAIR, 14'd1, 8'd200);
        add_ticks(45);
        add_command(WAVE_TRIANGLE, 14'd1, 8'd2);
        add_ticks(60);
        add_command(WAVE_SINE, 14'd1, 8'd4);
        add_ticks(10);
        add_command(WAVE_RECT, 14'd1, 8'd2);
        add_ticks(60);
        wait_drained();

        // random: mostly well-formed commands with tick bursts, plus noise
        n = 0;
        while (n < 280)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                if ($urandom_range(0, 1))
                    add_byte(8'($urandom));
                else
                    add_ticks($urandom_range(1, 3));
                n += 2;
            end
            else
            begin
                add_random_command();
                add_ticks($urandom_range(5, 60));
                if ($urandom_range(0, 1))
                    add_byte(8'($urandom));
                n += 35;
            end
            while (pending_requests.size() > 64)
                @(posedge clk);
        end
        wait_drained();
        repeat (DrainCycles) @(posedge clk);

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
